// File: hdl/dilp_pkg.sv
// shared types and constants for the delimited integer list parser
// no dependencies; used by dilp_field_core and delimited_integer_list_parser
package dilp_pkg;

    localparam logic [7:0]  SEP_RESET  = 8'd44;
    localparam logic [7:0]  CH_PLUS    = 8'd43;
    localparam logic [7:0]  CH_MINUS   = 8'd45;
    localparam logic [7:0]  CH_ZERO    = 8'd48;
    localparam logic [7:0]  CH_NINE    = 8'd57;
    localparam logic [7:0]  CH_SPACE   = 8'd32;
    localparam logic [7:0]  CH_TAB     = 8'd9;
    localparam logic [7:0]  CH_CR      = 8'd13;
    localparam logic [31:0] POS_LIMIT  = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_LIMIT  = 32'h8000_0000;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_byte;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] field_value;
        logic               saturated;
        logic               last_value;
    } t_out_item;

endpackage

// File: hdl/dilp_field_core.sv
// per-field atoi state and its byte update
// depends on dilp_pkg
module dilp_field_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  dilp_pkg::t_in_item i_item,
    input  logic [7:0]         i_sep,
    output logic               o_emit,
    output dilp_pkg::t_out_item o_result
);

    typedef enum logic [1:0] {
        PH_SPACE,
        PH_SIGN,
        PH_DIGITS,
        PH_STOP
    } t_phase;

    t_phase      r_phase, n_phase;
    logic        r_neg, n_neg;
    logic [31:0] r_mag, n_mag;
    logic        r_ovf, n_ovf;

    logic        is_sep, is_blank, is_digit, is_sign;
    logic [3:0]  digit;
    logic [35:0] prod;
    logic [31:0] limit;
    logic        over;
    logic        take_digit;

    always_comb begin
        is_sep   = (i_item.text_byte == i_sep);
        is_blank = (i_item.text_byte == dilp_pkg::CH_SPACE) ||
                   ((i_item.text_byte >= dilp_pkg::CH_TAB) &&
                    (i_item.text_byte <= dilp_pkg::CH_CR));
        is_digit = (i_item.text_byte >= dilp_pkg::CH_ZERO) &&
                   (i_item.text_byte <= dilp_pkg::CH_NINE);
        is_sign  = (i_item.text_byte == dilp_pkg::CH_PLUS) ||
                   (i_item.text_byte == dilp_pkg::CH_MINUS);
        digit    = 4'(i_item.text_byte - dilp_pkg::CH_ZERO);

        // sign only changes before the first digit, so the current sign sets the clamp
        limit = r_neg ? dilp_pkg::NEG_LIMIT : dilp_pkg::POS_LIMIT;
        prod  = ({4'd0, r_mag} << 3) + ({4'd0, r_mag} << 1) + {32'd0, digit};
        over  = (prod > {4'd0, limit});

        n_phase    = r_phase;
        n_neg      = r_neg;
        n_mag      = r_mag;
        n_ovf      = r_ovf;
        take_digit = 1'b0;

        if (!is_sep) begin
            case (r_phase)
                PH_SPACE: begin
                    if (is_blank) begin
                        n_phase = PH_SPACE;
                    end else if (is_sign) begin
                        n_neg   = (i_item.text_byte == dilp_pkg::CH_MINUS);
                        n_phase = PH_SIGN;
                    end else if (is_digit) begin
                        take_digit = 1'b1;
                        n_phase    = PH_DIGITS;
                    end else begin
                        n_phase = PH_STOP;
                    end
                end
                PH_SIGN, PH_DIGITS: begin
                    if (is_digit) begin
                        take_digit = 1'b1;
                        n_phase    = PH_DIGITS;
                    end else begin
                        n_phase = PH_STOP;
                    end
                end
                default: begin
                    n_phase = PH_STOP;
                end
            endcase
        end

        if (take_digit) begin
            if (over) begin
                n_mag = limit;
                n_ovf = 1'b1;
            end else begin
                n_mag = prod[31:0];
            end
        end

        o_emit               = is_sep || i_item.final_byte;
        o_result.field_value = n_neg ? $signed(32'd0 - n_mag) : $signed(n_mag);
        o_result.saturated   = n_ovf;
        o_result.last_value  = i_item.final_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SPACE;
            r_neg   <= 1'b0;
            r_mag   <= 32'd0;
            r_ovf   <= 1'b0;
        end else if (i_step) begin
            if (o_emit) begin
                r_phase <= PH_SPACE;
                r_neg   <= 1'b0;
                r_mag   <= 32'd0;
                r_ovf   <= 1'b0;
            end else begin
                r_phase <= n_phase;
                r_neg   <= n_neg;
                r_mag   <= n_mag;
                r_ovf   <= n_ovf;
            end
        end
    end

endmodule

// File: hdl/delimited_integer_list_parser.sv
// top level of the delimited integer list parser: input register, field core, result register
// depends on dilp_pkg and dilp_field_core
//
// usage
// - input channel i_in_valid / o_in_ready carries one byte of text per transaction,
//   with final_byte high on the last byte of a string
// - output channel o_out_valid / i_out_ready carries one parsed integer per transaction:
//   one at every separator byte, and one at a final byte that is not a separator;
//   last_value marks the final integer of the string
// - i_cfg_we / i_cfg_data write the separator byte (reset value is a comma);
//   write it only while the block is idle
// - a byte accepted into the input register is processed by the field core, and a result
//   that it gives is captured in the result register, from which it is presented
// - throughput: one byte per cycle while no byte that gives a result waits for the result register,
//   set by the multiply-by-ten-and-add update of the field accumulator between the input and result registers
// - reset (synchronous, active low) empties both registers, clears the field state
//   and restores the comma separator
// - when the receiver stalls, one more byte is still taken into the input register;
//   bytes that give no result keep flowing, and a byte that gives a result waits
//   until the result register is free, holding o_in_ready low meanwhile
module delimited_integer_list_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  dilp_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output dilp_pkg::t_out_item o_out_item,
    input  logic                i_cfg_we,
    input  logic [7:0]          i_cfg_data
);

    // configuration register
    logic [7:0] r_sep;

    // input register
    logic               r_in_valid;
    dilp_pkg::t_in_item r_in;

    // result register
    logic                r_out_valid;
    dilp_pkg::t_out_item r_out;

    // processing stage
    logic                core_emit;
    dilp_pkg::t_out_item core_result;
    logic                out_free;
    logic                proc_fire;
    logic                in_take;

    dilp_field_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (proc_fire),
        .i_item   (r_in),
        .i_sep    (r_sep),
        .o_emit   (core_emit),
        .o_result (core_result)
    );

    // result slot is free when empty or being drained this cycle
    assign out_free   = !r_out_valid || i_out_ready;
    // a byte with no result never needs the slot
    assign proc_fire  = r_in_valid && (!core_emit || out_free);
    assign o_in_ready = !r_in_valid || proc_fire;
    assign in_take    = i_in_valid && o_in_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep       <= dilp_pkg::SEP_RESET;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_sep <= i_cfg_data;
            end

            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (proc_fire) begin
                r_in_valid <= 1'b0;
            end

            if (proc_fire && core_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_item;
        end
        if (proc_fire && core_emit) begin
            r_out <= core_result;
        end
    end

    // a clamped value is always one of the two limits
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.saturated) |->
            (r_out.field_value == $signed(dilp_pkg::POS_LIMIT) ||
             r_out.field_value == $signed(dilp_pkg::NEG_LIMIT)))
        else $error("saturated result is not a limit value");

    // a held byte stays put until it is processed
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !proc_fire) |=> (r_in_valid && $stable(r_in)))
        else $error("pending input byte lost or changed");

    // input stalls only behind a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_valid && r_out_valid && !i_out_ready))
        else $error("input stalled without a stalled result");

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_out)))
        else $error("pending result overwritten or dropped");

endmodule
